### src/retransmission_queue_top_macros.svh
// ----------------------------------------------------------------------------
// Retransmission queue assertion macros
// Concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef RETRANSMISSION_QUEUE_TOP_MACROS_SVH
`define RETRANSMISSION_QUEUE_TOP_MACROS_SVH

`ifndef SYNTH
`define RTQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("retransmission queue check failed");
`define RTQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("retransmission queue check failed");
`else
`define RTQ_ASSERT_SAME(lbl, ante, cons)
`define RTQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### src/rtq_pkg.sv
// ----------------------------------------------------------------------------
// Retransmission queue package
// Sizes, operation and status codes, entry layout and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package rtq_pkg;

  localparam int CAPACITY        = 16;
  localparam int MAX_SEGMENT_LEN = 1460;

  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int SEQ_W   = 32;
  localparam int LEN_W   = 11;
  localparam int TIME_W  = 32;
  localparam int RETRY_W = 8;

  localparam logic [CNT_W-1:0]   CAP_CNT       = CNT_W'(CAPACITY);
  localparam logic [LEN_W-1:0]   MAX_LEN       = LEN_W'(MAX_SEGMENT_LEN);
  localparam logic [RETRY_W-1:0] RETRY_MAX     = '1;
  localparam logic [TIME_W-1:0]  TIMEOUT_RESET = TIME_W'(1000);

  typedef enum logic [1:0] {
    FUNC_PUSH    = 2'd0,
    FUNC_ACK     = 2'd1,
    FUNC_FIND    = 2'd2,
    FUNC_TIMEOUT = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_TOO_LONG = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [SEQ_W-1:0]   seq;
    logic [LEN_W-1:0]   length;
    logic [TIME_W-1:0]  sent_at;
    logic [RETRY_W-1:0] retries;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic   hit;
    entry_t upd;
  } alu_res_t;

endpackage

`default_nettype wire

### src/retransmission_queue_top.sv
// ----------------------------------------------------------------------------
// Retransmission queue
// Insertion-ordered table of sent segments with push, ack, find and timeout.
// ----------------------------------------------------------------------------
// Push: the item passes through the push and done states before the result
// is registered. Ack, find, timeout: one entry per cycle through the entry
// unit and RAM read port, over all entries held (up to 16), then the done state.
// A new item is taken only in the idle state, after the last result is loaded.
// A result held by out_ready low stalls the next item.
// Reset empties the queue and sets the timeout to 1000 ticks.
`default_nettype none

module retransmission_queue_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [rtq_pkg::TIME_W-1:0]        cfg_wr_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        func,
  input  wire logic [rtq_pkg::SEQ_W-1:0]         seq_num,
  input  wire logic [rtq_pkg::LEN_W-1:0]         seg_length,
  input  wire logic [rtq_pkg::TIME_W-1:0]        time_now,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [1:0]                             op_status,
  output logic [rtq_pkg::CNT_W-1:0]              affected_count,
  output logic                                   found,
  output logic [rtq_pkg::LEN_W-1:0]              found_length,
  output logic [rtq_pkg::TIME_W-1:0]             found_sent_at,
  output logic [rtq_pkg::RETRY_W-1:0]            found_retries,
  output logic [rtq_pkg::CNT_W-1:0]              queue_size,
  output logic                                   queue_empty
);

  `include "retransmission_queue_top_macros.svh"

  rtq_pkg::state_t  state, state_next;
  rtq_pkg::func_t   op;
  rtq_pkg::status_t status, status_next;

  logic [rtq_pkg::TIME_W-1:0]  retx_timeout;
  logic [rtq_pkg::CNT_W-1:0]   total, total_next;
  logic [rtq_pkg::CNT_W-1:0]   rd_idx, rd_idx_next;
  logic [rtq_pkg::CNT_W-1:0]   wr_idx, wr_idx_next;
  logic [rtq_pkg::CNT_W-1:0]   proc_idx;
  logic [rtq_pkg::CNT_W-1:0]   affected, affected_next;
  logic                        pend, pend_next;
  logic                        hit_found, hit_found_next;
  logic                        out_valid_next;
  logic                        out_load;
  logic                        accept;
  logic                        capture;
  logic                        issue;

  logic [rtq_pkg::SEQ_W-1:0]   key;
  logic [rtq_pkg::LEN_W-1:0]   len;
  logic [rtq_pkg::TIME_W-1:0]  now;
  rtq_pkg::entry_t             cap_entry;

  logic                        ram_wr_en;
  logic [rtq_pkg::IDX_W-1:0]   ram_wr_addr;
  logic [rtq_pkg::ENTRY_W-1:0] ram_wr_data;
  logic [rtq_pkg::IDX_W-1:0]   ram_rd_addr;
  logic [rtq_pkg::ENTRY_W-1:0] ram_rd_data;
  rtq_pkg::entry_t             rd_entry;
  rtq_pkg::entry_t             push_entry;
  rtq_pkg::alu_res_t           alu_res;

  assign rd_entry = rtq_pkg::entry_t'(ram_rd_data);
  assign accept   = in_valid && in_ready;
  assign proc_idx = rd_idx - 1'b1;

  rtq_ram #(
    .WIDTH (rtq_pkg::ENTRY_W),
    .DEPTH (rtq_pkg::CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  rtq_alu u_alu (
    .op      (op),
    .key     (key),
    .now     (now),
    .timeout (retx_timeout),
    .entry   (rd_entry),
    .res     (alu_res)
  );

  always_comb begin
    push_entry.seq     = key;
    push_entry.length  = len;
    push_entry.sent_at = now;
    push_entry.retries = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rtq_pkg::ST_IDLE;
      status       <= rtq_pkg::STATUS_OK;
      total        <= '0;
      rd_idx       <= '0;
      wr_idx       <= '0;
      affected     <= '0;
      pend         <= 1'b0;
      hit_found    <= 1'b0;
      out_valid    <= 1'b0;
      retx_timeout <= rtq_pkg::TIMEOUT_RESET;
    end else begin
      state     <= state_next;
      status    <= status_next;
      total     <= total_next;
      rd_idx    <= rd_idx_next;
      wr_idx    <= wr_idx_next;
      affected  <= affected_next;
      pend      <= pend_next;
      hit_found <= hit_found_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        retx_timeout <= cfg_wr_data;
      end
    end
  end

  always_comb begin
    state_next     = state;
    status_next    = status;
    total_next     = total;
    rd_idx_next    = rd_idx;
    wr_idx_next    = wr_idx;
    affected_next  = affected;
    pend_next      = pend;
    hit_found_next = hit_found;
    in_ready       = 1'b0;
    out_load       = 1'b0;
    capture        = 1'b0;
    issue          = 1'b0;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = total[rtq_pkg::IDX_W-1:0];
    ram_wr_data    = alu_res.upd;
    ram_rd_addr    = rd_idx[rtq_pkg::IDX_W-1:0];
    case (state)
      rtq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          rd_idx_next    = '0;
          wr_idx_next    = '0;
          affected_next  = '0;
          pend_next      = 1'b0;
          hit_found_next = 1'b0;
          status_next    = rtq_pkg::STATUS_OK;
          if (rtq_pkg::func_t'(func) == rtq_pkg::FUNC_PUSH) begin
            state_next = rtq_pkg::ST_PUSH;
          end else begin
            state_next = rtq_pkg::ST_SCAN;
          end
        end
      end
      rtq_pkg::ST_PUSH: begin
        if (total >= rtq_pkg::CAP_CNT) begin
          status_next = rtq_pkg::STATUS_FULL;
        end else if (len > rtq_pkg::MAX_LEN) begin
          status_next = rtq_pkg::STATUS_TOO_LONG;
        end else begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = total[rtq_pkg::IDX_W-1:0];
          ram_wr_data = push_entry;
          total_next  = total + 1'b1;
        end
        state_next = rtq_pkg::ST_DONE;
      end
      rtq_pkg::ST_SCAN: begin
        issue       = (rd_idx < total);
        pend_next   = issue;
        rd_idx_next = rd_idx + {{(rtq_pkg::CNT_W-1){1'b0}}, issue};
        if (pend) begin
          case (op)
            rtq_pkg::FUNC_ACK: begin
              if (alu_res.hit) begin
                affected_next = affected + 1'b1;
              end else begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = wr_idx[rtq_pkg::IDX_W-1:0];
                ram_wr_data = rd_entry;
                wr_idx_next = wr_idx + 1'b1;
              end
            end
            rtq_pkg::FUNC_FIND: begin
              if (alu_res.hit && !hit_found) begin
                capture        = 1'b1;
                hit_found_next = 1'b1;
              end
            end
            rtq_pkg::FUNC_TIMEOUT: begin
              if (alu_res.hit) begin
                ram_wr_en     = 1'b1;
                ram_wr_addr   = proc_idx[rtq_pkg::IDX_W-1:0];
                ram_wr_data   = alu_res.upd;
                affected_next = affected + 1'b1;
              end
            end
            default: begin
              capture = 1'b0;
            end
          endcase
        end
        if (!issue && !pend) begin
          if (op == rtq_pkg::FUNC_ACK) begin
            total_next = wr_idx;
          end
          state_next = rtq_pkg::ST_DONE;
        end
      end
      rtq_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = rtq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rtq_pkg::ST_IDLE;
      end
    endcase
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= rtq_pkg::func_t'(func);
      key       <= seq_num;
      len       <= seg_length;
      now       <= time_now;
      cap_entry <= '0;
    end else if (capture) begin
      cap_entry <= rd_entry;
    end
    if (out_load) begin
      op_status      <= status;
      affected_count <= affected;
      found          <= hit_found;
      found_length   <= cap_entry.length;
      found_sent_at  <= cap_entry.sent_at;
      found_retries  <= cap_entry.retries;
      queue_size     <= total;
      queue_empty    <= (total == '0);
    end
  end

  `RTQ_ASSERT_SAME(a_total_cap, 1'b1, total <= rtq_pkg::CAP_CNT)
  `RTQ_ASSERT_SAME(a_write_behind, state == rtq_pkg::ST_SCAN, wr_idx <= rd_idx)
  `RTQ_ASSERT_SAME(a_affected_bound, state == rtq_pkg::ST_SCAN, affected <= rd_idx)
  `RTQ_ASSERT_NEXT(a_push_grow,
                   state == rtq_pkg::ST_PUSH && status_next == rtq_pkg::STATUS_OK,
                   total == $past(total) + 1'b1)
  `RTQ_ASSERT_NEXT(a_scan_keeps_total,
                   state == rtq_pkg::ST_SCAN && op != rtq_pkg::FUNC_ACK,
                   total == $past(total))

endmodule

`default_nettype wire

### src/rtq_ram.sv
// ----------------------------------------------------------------------------
// Retransmission queue RAM
// Generic single write, single read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                          wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### src/rtq_alu.sv
// ----------------------------------------------------------------------------
// Retransmission queue entry unit
// Compare and update of one entry for ack, find and timeout scans.
// ----------------------------------------------------------------------------
`default_nettype none

module rtq_alu (
  input  wire rtq_pkg::func_t               op,
  input  wire logic [rtq_pkg::SEQ_W-1:0]    key,
  input  wire logic [rtq_pkg::TIME_W-1:0]   now,
  input  wire logic [rtq_pkg::TIME_W-1:0]   timeout,
  input  wire rtq_pkg::entry_t              entry,
  output rtq_pkg::alu_res_t                 res
);

  logic [rtq_pkg::TIME_W-1:0] age;

  always_comb begin
    age                = now - entry.sent_at;
    res.upd            = entry;
    res.hit            = 1'b0;
    case (op)
      rtq_pkg::FUNC_ACK: begin
        res.hit = (entry.seq < key);
      end
      rtq_pkg::FUNC_FIND: begin
        res.hit = (entry.seq == key);
      end
      rtq_pkg::FUNC_TIMEOUT: begin
        res.hit         = (age >= timeout);
        res.upd.sent_at = now;
        if (entry.retries != rtq_pkg::RETRY_MAX) begin
          res.upd.retries = entry.retries + 1'b1;
        end
      end
      default: begin
        res.hit = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire
